[rtl/nav_cs_pkg.sv]
// shared codes, field widths and constants for the nav carrier sense block
package nav_cs_pkg;

  localparam int ADDR_W  = 48;
  localparam int DELAY_W = 16;
  localparam int NAV_W   = 15;
  localparam int TIME_W  = 32;
  localparam int REQ_W   = 3;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 24;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_TICK     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_RX_STATE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RX_PART  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TX_STATE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FRAME_RX = 3'd4;
  localparam logic [REQ_W-1:0] REQ_FRAME_TX = 3'd5;

  // radio state codes
  localparam logic [1:0] RX_IDLE      = 2'd1;
  localparam logic [1:0] RX_RECEIVING = 2'd3;
  localparam logic [2:0] PART_WHOLE   = 3'd1;
  localparam logic [2:0] PART_DATA    = 3'd4;
  localparam logic [1:0] TX_UNDEFINED = 2'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_DELAY = 1'd1;

  // due notifications delivered per tick at most
  localparam logic [2:0] MAX_DRAIN = 3'd7;

  typedef struct packed {
    logic             queue_overflow;
    logic [NAV_W-1:0] nav_remaining;
    logic             reception_in_progress;
    logic             corrupted_frame;
    logic             mac_view_free;
    logic             notify_free;
    logic             notify_valid;
    logic             medium_free;
  } result_t;

endpackage

[rtl/nav_cs_ram.sv]
// generic single-port-write, registered-read ram
module nav_cs_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/nav_carrier_sense_core.sv]
// nav carrier sense core: medium state, nav countdown and delayed notification queue
// sequence: a non-tick event goes from idle to fin, through rec when the medium state is
//   recomputed; a tick goes through rd and chk once per head-of-queue check (at most 7 per
//   tick), then nav, then rec when the nav expires, then fin; output back-pressure can hold chk, rec and fin
// throughput: one event at a time, the next transfer is taken the cycle after the last result loads
// reset: synchronous, clears control and medium state; the pending ram is not cleared
module nav_carrier_sense_core #(
  parameter int PENDING_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  // cfg write port
  input  logic                                cfg_we,
  input  logic [nav_cs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nav_cs_pkg::CFG_W-1:0]        cfg_data,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rx_state[1:0], rx_part[4:2], tx_state[6:5], fcs_ok[7], receiver_address[55:8],
  // nav_duration[70:56], zero[71]
  input  logic [nav_cs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // req_type[2:0]
  input  logic [nav_cs_pkg::REQ_W-1:0]        s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // medium_free[0], notify_valid[1], notify_free[2], mac_view_free[3],
  // corrupted_frame[4], reception_in_progress[5], nav_remaining[20:6],
  // queue_overflow[21], zero[23:22]
  output logic [nav_cs_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int ENT_W = nav_cs_pkg::TIME_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_CHK  = 6'b000100,
    ST_NAV  = 6'b001000,
    ST_REC  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [nav_cs_pkg::ADDR_W-1:0]  own_address;
  logic [nav_cs_pkg::DELAY_W-1:0] notify_delay;

  // medium state
  logic [1:0]                     reception_state;
  logic [2:0]                     signal_part;
  logic [1:0]                     transmission_state;
  logic                           free_flag;
  logic [nav_cs_pkg::NAV_W-1:0]   nav_count;
  logic                           mac_view;
  logic [nav_cs_pkg::TIME_W-1:0]  tick_time;
  logic                           corrupt;
  logic [2:0]                     drained;

  // pending queue pointers
  logic [PTR_W-1:0] pend_head;
  logic [PTR_W-1:0] pend_tail;
  logic [CNT_W-1:0] pend_count;

  // result staging: one held result so the last flag can be set once known
  nav_cs_pkg::result_t hold_res;
  logic                hold_valid;
  nav_cs_pkg::result_t out_res;

  // input fields
  logic [1:0]                    in_rx_state;
  logic [2:0]                    in_rx_part;
  logic [1:0]                    in_tx_state;
  logic                          in_fcs_ok;
  logic [nav_cs_pkg::ADDR_W-1:0] in_addr;
  logic [nav_cs_pkg::NAV_W-1:0]  in_dur;

  assign in_rx_state = s_axis_tdata[1:0];
  assign in_rx_part  = s_axis_tdata[4:2];
  assign in_tx_state = s_axis_tdata[6:5];
  assign in_fcs_ok   = s_axis_tdata[7];
  assign in_addr     = s_axis_tdata[55:8];
  assign in_dur      = s_axis_tdata[70:56];

  logic in_accept;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // ram
  logic             ram_wr_en;
  logic             ram_rd_en;
  logic [ENT_W-1:0] ram_wr_data;
  logic [ENT_W-1:0] ram_rd_data;

  nav_cs_ram #(
    .WIDTH (ENT_W),
    .DEPTH (PENDING_DEPTH)
  ) u_pend_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (pend_tail),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (pend_head),
    .rd_data (ram_rd_data)
  );

  // head entry: due time above, free bit at bit 0
  logic [nav_cs_pkg::TIME_W-1:0] head_due;
  logic                          head_free;
  logic [nav_cs_pkg::TIME_W-1:0] head_age;
  logic                          head_ready;

  assign head_due   = ram_rd_data[ENT_W-1:1];
  assign head_free  = ram_rd_data[0];
  assign head_age   = tick_time - head_due;
  assign head_ready = !head_age[nav_cs_pkg::TIME_W-1];

  // recompute terms
  logic new_free;
  logic free_change;
  logic pend_full;
  logic delay_zero;
  logic nav_update;
  logic rip;

  assign new_free    = (reception_state == nav_cs_pkg::RX_IDLE) &&
                       (transmission_state == nav_cs_pkg::TX_UNDEFINED) && (nav_count == '0);
  assign free_change = (new_free != free_flag);
  assign pend_full   = (pend_count == CNT_W'(PENDING_DEPTH));
  assign delay_zero  = (notify_delay == '0);
  assign nav_update  = (in_dur != '0) && !((nav_count != '0) && (in_dur < nav_count));
  assign rip         = (reception_state == nav_cs_pkg::RX_RECEIVING) &&
                       ((signal_part == nav_cs_pkg::PART_WHOLE) ||
                        (signal_part == nav_cs_pkg::PART_DATA));

  assign ram_rd_en   = (state == ST_RD);
  assign ram_wr_en   = (state == ST_REC) && free_change && !delay_zero && !pend_full;
  assign ram_wr_data = {tick_time + nav_cs_pkg::TIME_W'(notify_delay), new_free};

  // result forming
  nav_cs_pkg::result_t base_res;
  nav_cs_pkg::result_t emit_res;
  nav_cs_pkg::result_t final_res;
  logic                emit_req;
  logic                can_emit;
  logic                emit_fire;
  logic                out_free;
  logic                load_out;

  always_comb begin
    base_res                       = '0;
    base_res.medium_free           = free_flag;
    base_res.mac_view_free         = mac_view;
    base_res.reception_in_progress = rip;
    base_res.nav_remaining         = nav_count;

    emit_req = 1'b0;
    emit_res = base_res;
    case (state)
      ST_CHK: begin
        emit_req               = head_ready;
        emit_res.notify_valid  = 1'b1;
        emit_res.notify_free   = head_free;
        emit_res.mac_view_free = head_free;
      end
      ST_REC: begin
        emit_req             = free_change && (delay_zero || pend_full);
        emit_res.medium_free = new_free;
        if (delay_zero) begin
          emit_res.notify_valid = 1'b1;
          emit_res.notify_free  = new_free;
        end else begin
          emit_res.queue_overflow = 1'b1;
        end
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase

    final_res                 = base_res;
    final_res.corrupted_frame = corrupt;
  end

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign can_emit  = !hold_valid || out_free;
  assign emit_fire = emit_req && can_emit;
  // output register takes a transfer from the hold slot or the closing result
  assign load_out  = (emit_fire && hold_valid) || ((state == ST_FIN) && out_free);

  // pointer wrap
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  assign head_inc = (pend_head == PTR_W'(PENDING_DEPTH - 1)) ? '0 : pend_head + 1'b1;
  assign tail_inc = (pend_tail == PTR_W'(PENDING_DEPTH - 1)) ? '0 : pend_tail + 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address  <= '0;
      notify_delay <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        nav_cs_pkg::CFG_OWN_ADDRESS:  own_address  <= cfg_data;
        nav_cs_pkg::CFG_NOTIFY_DELAY: notify_delay <= cfg_data[nav_cs_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      reception_state    <= '0;
      signal_part        <= '0;
      transmission_state <= '0;
      free_flag          <= 1'b0;
      nav_count          <= '0;
      mac_view           <= 1'b1;
      tick_time          <= '0;
      corrupt            <= 1'b0;
      drained            <= '0;
      pend_head          <= '0;
      pend_tail          <= '0;
      pend_count         <= '0;
      hold_valid         <= 1'b0;
      m_axis_tvalid      <= 1'b0;
      m_axis_tlast       <= 1'b0;
    end else begin
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      if (emit_fire) begin
        if (hold_valid) begin
          out_res      <= hold_res;
          m_axis_tlast <= 1'b0;
        end
        hold_res   <= emit_res;
        hold_valid <= 1'b1;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            corrupt <= (s_axis_tuser == nav_cs_pkg::REQ_FRAME_RX) && !in_fcs_ok;
            case (s_axis_tuser)
              nav_cs_pkg::REQ_TICK: begin
                tick_time <= tick_time + 1'b1;
                drained   <= '0;
                state     <= (pend_count != '0) ? ST_RD : ST_NAV;
              end
              nav_cs_pkg::REQ_RX_STATE: begin
                reception_state <= in_rx_state;
                state           <= ST_REC;
              end
              nav_cs_pkg::REQ_RX_PART: begin
                signal_part <= in_rx_part;
                state       <= ST_REC;
              end
              nav_cs_pkg::REQ_TX_STATE: begin
                transmission_state <= in_tx_state;
                state              <= ST_REC;
              end
              nav_cs_pkg::REQ_FRAME_RX: begin
                if (!in_fcs_ok) begin
                  state <= ST_FIN;
                end else if ((in_addr != own_address) && nav_update) begin
                  nav_count <= in_dur;
                  state     <= ST_REC;
                end else begin
                  state <= ST_FIN;
                end
              end
              nav_cs_pkg::REQ_FRAME_TX: begin
                if (nav_update) begin
                  nav_count <= in_dur;
                  state     <= ST_REC;
                end else begin
                  state <= ST_FIN;
                end
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (!head_ready) begin
            state <= ST_NAV;
          end else if (can_emit) begin
            mac_view   <= head_free;
            pend_head  <= head_inc;
            pend_count <= pend_count - 1'b1;
            drained    <= drained + 1'b1;
            if ((pend_count != CNT_W'(1)) && (drained != nav_cs_pkg::MAX_DRAIN - 1'b1)) begin
              state <= ST_RD;
            end else begin
              state <= ST_NAV;
            end
          end
        end
        ST_NAV: begin
          if (nav_count != '0) begin
            nav_count <= nav_count - 1'b1;
            state     <= (nav_count == nav_cs_pkg::NAV_W'(1)) ? ST_REC : ST_FIN;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_REC: begin
          if (!free_change) begin
            state <= ST_FIN;
          end else if (delay_zero || pend_full) begin
            if (can_emit) begin
              free_flag <= new_free;
              state     <= ST_FIN;
            end
          end else begin
            free_flag  <= new_free;
            pend_tail  <= tail_inc;
            pend_count <= pend_count + 1'b1;
            state      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_res      <= hold_valid ? hold_res : final_res;
            m_axis_tlast <= 1'b1;
            hold_valid   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tdata = {2'b00, out_res};

  // queue occupancy never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= CNT_W'(PENDING_DEPTH))
    else $error("pending count above depth");

  // a head check only happens with something queued
  a_chk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |-> (pend_count != '0))
    else $error("head check on empty queue");

  // no result is held over between events
  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !hold_valid)
    else $error("held result left in idle");

  // a tick never delivers more than the drain limit
  a_drain_limit: assert property (@(posedge clk) disable iff (rst)
    drained <= nav_cs_pkg::MAX_DRAIN)
    else $error("drain limit exceeded");

  // a pushed notification grows the queue by one
  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |=> (pend_count == $past(pend_count) + 1'b1))
    else $error("push did not grow queue");

endmodule

[dv/nav_cs_checker.sv]
// carrier sense checker: watches the event and result streams, predicts results, compares them
module nav_cs_checker #(
  parameter int PENDING_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [nav_cs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nav_cs_pkg::CFG_W-1:0]       cfg_data,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [nav_cs_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [nav_cs_pkg::REQ_W-1:0]       s_tuser,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  input  logic [nav_cs_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                               m_tlast,
  output int                                 fails,
  output int                                 outstanding,
  output int                                 n_results,
  output int                                 n_notes,
  output int                                 n_overflows
);

  localparam int MAX_REPORTS = 8;

  typedef struct packed {
    nav_cs_pkg::result_t res;
    logic                last;
  } report_t;

  // register copies
  logic [nav_cs_pkg::ADDR_W-1:0]  own_addr;
  logic [nav_cs_pkg::DELAY_W-1:0] delay_ticks;

  // medium state
  logic [1:0]                    rx_st;
  logic [2:0]                    part_st;
  logic [1:0]                    tx_st;
  logic                          medium_free;
  logic [nav_cs_pkg::NAV_W-1:0]  nav_left;
  logic                          mac_view;
  logic [nav_cs_pkg::TIME_W-1:0] now_ticks;

  // pending notification ring
  logic [nav_cs_pkg::TIME_W-1:0] due_at [PENDING_DEPTH];
  logic                          due_free [PENDING_DEPTH];
  int unsigned                   pend_n;
  int unsigned                   pend_head;

  report_t event_reports[$];
  report_t predicted_status[$];

  task automatic note_status(input logic nv, input logic nf, input logic corr, input logic ovf);
    report_t r;
    if (event_reports.size() < MAX_REPORTS) begin
      r.res.medium_free           = medium_free;
      r.res.notify_valid          = nv;
      r.res.notify_free           = nv & nf;
      r.res.mac_view_free         = mac_view;
      r.res.corrupted_frame       = corr;
      r.res.reception_in_progress = (rx_st == nav_cs_pkg::RX_RECEIVING) &&
                                    (part_st == nav_cs_pkg::PART_WHOLE ||
                                     part_st == nav_cs_pkg::PART_DATA);
      r.res.nav_remaining         = nav_left;
      r.res.queue_overflow        = ovf;
      r.last                      = 1'b0;
      event_reports.insert(event_reports.size(), r);
    end
  endtask

  task automatic reevaluate_medium();
    logic        now_free;
    int unsigned slot;
    now_free = (rx_st == nav_cs_pkg::RX_IDLE) && (tx_st == nav_cs_pkg::TX_UNDEFINED) &&
               (nav_left == '0);
    if (now_free != medium_free) begin
      medium_free = now_free;
      if (delay_ticks == '0) begin
        note_status(1'b1, now_free, 1'b0, 1'b0);
      end else if (pend_n >= PENDING_DEPTH) begin
        note_status(1'b0, 1'b0, 1'b0, 1'b1);
      end else begin
        slot = (pend_head + pend_n) % PENDING_DEPTH;
        due_at[slot]   = now_ticks + {16'd0, delay_ticks};
        due_free[slot] = now_free;
        pend_n++;
      end
    end
  endtask

  // nav is set or extended, never shortened
  task automatic extend_nav(input logic [nav_cs_pkg::NAV_W-1:0] dur);
    if (dur != '0 && !(nav_left != '0 && dur < nav_left)) begin
      nav_left = dur;
      reevaluate_medium();
    end
  endtask

  task automatic advance_carrier_sense(input logic [nav_cs_pkg::REQ_W-1:0] req,
                                       input logic [nav_cs_pkg::IN_DATA_W-1:0] d);
    int                            drained;
    logic                          corrupt;
    logic                          waiting;
    logic [nav_cs_pkg::TIME_W-1:0] age;
    report_t                       tail;
    event_reports.delete();
    corrupt = 1'b0;
    case (req)
      nav_cs_pkg::REQ_TICK: begin
        now_ticks = now_ticks + 1;
        drained   = 0;
        waiting   = 1'b0;
        // only the head is tested, a later entry never overtakes it
        while (pend_n > 0 && drained < nav_cs_pkg::MAX_DRAIN && !waiting) begin
          age = now_ticks - due_at[pend_head];
          if (age[nav_cs_pkg::TIME_W-1]) begin
            waiting = 1'b1;
          end else begin
            mac_view = due_free[pend_head];
            note_status(1'b1, due_free[pend_head], 1'b0, 1'b0);
            pend_head = (pend_head + 1) % PENDING_DEPTH;
            pend_n--;
            drained++;
          end
        end
        if (nav_left != '0) begin
          nav_left = nav_left - 1'b1;
          if (nav_left == '0) reevaluate_medium();
        end
      end
      nav_cs_pkg::REQ_RX_STATE: begin
        rx_st = d[1:0];
        reevaluate_medium();
      end
      nav_cs_pkg::REQ_RX_PART: begin
        part_st = d[4:2];
        reevaluate_medium();
      end
      nav_cs_pkg::REQ_TX_STATE: begin
        tx_st = d[6:5];
        reevaluate_medium();
      end
      nav_cs_pkg::REQ_FRAME_RX: begin
        if (d[7]) begin
          if (d[55:8] != own_addr) extend_nav(d[70:56]);
        end else begin
          corrupt = 1'b1;
        end
      end
      nav_cs_pkg::REQ_FRAME_TX: extend_nav(d[70:56]);
      default: ;
    endcase
    if (corrupt) note_status(1'b0, 1'b0, 1'b1, 1'b0);
    if (event_reports.size() == 0) note_status(1'b0, 1'b0, 1'b0, 1'b0);
    tail = event_reports.pop_back();
    tail.last = 1'b1;
    event_reports.insert(event_reports.size(), tail);
    while (event_reports.size() > 0) begin
      tail = event_reports.pop_front();
      predicted_status.insert(predicted_status.size(), tail);
    end
  endtask

  function automatic string describe(report_t r);
    return $sformatf("free=%0d nv=%0d nf=%0d mac=%0d corrupt=%0d rip=%0d nav=%0d ovf=%0d last=%0d",
                     r.res.medium_free, r.res.notify_valid, r.res.notify_free,
                     r.res.mac_view_free, r.res.corrupted_frame,
                     r.res.reception_in_progress, r.res.nav_remaining,
                     r.res.queue_overflow, r.last);
  endfunction

  task automatic flag_error(input string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endtask

  initial begin
    fails       = 0;
    outstanding = 0;
    n_results   = 0;
    n_notes     = 0;
    n_overflows = 0;
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      own_addr    = '0;
      delay_ticks = '0;
      rx_st       = '0;
      part_st     = '0;
      tx_st       = '0;
      medium_free = 1'b0;
      nav_left    = '0;
      mac_view    = 1'b1;
      now_ticks   = '0;
      pend_n      = 0;
      pend_head   = 0;
      predicted_status.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == nav_cs_pkg::CFG_OWN_ADDRESS) begin
          own_addr = cfg_data[nav_cs_pkg::ADDR_W-1:0];
        end else if (cfg_index == nav_cs_pkg::CFG_NOTIFY_DELAY) begin
          delay_ticks = cfg_data[nav_cs_pkg::DELAY_W-1:0];
        end
      end
      if (s_tvalid && s_tready) advance_carrier_sense(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.res  = m_tdata[21:0];
        got.last = m_tlast;
        n_results++;
        if (got.res.notify_valid) n_notes++;
        if (got.res.queue_overflow) n_overflows++;
        if (predicted_status.size() == 0) begin
          flag_error($sformatf("result %0d with nothing expected: %s", n_results,
                               describe(got)));
        end else begin
          want = predicted_status.pop_front();
          if (got !== want || m_tdata[23:22] !== 2'b00)
            flag_error($sformatf("result %0d expected %s, got %s pad=%0d", n_results,
                                 describe(want), describe(got), m_tdata[23:22]));
        end
      end
    end
    outstanding = predicted_status.size();
  end

endmodule

[dv/nav_carrier_sense_core_tb.sv]
// carrier sense testbench top: clock, reset, event stimulus, result back-pressure and verdict
module nav_carrier_sense_core_tb;

  localparam int DEPTH        = 8;
  localparam int RANDOM_ITEMS = 205;
  localparam int PHASES       = 5;
  localparam int SETTLE       = 24;
  localparam int CYCLE_LIMIT  = 1000000;

  // codes the package does not name
  localparam logic [1:0]                   RX_BUSY      = 2'd2;
  localparam logic [1:0]                   TX_SENDING   = 2'd2;
  localparam logic [nav_cs_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [nav_cs_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [nav_cs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [nav_cs_pkg::CFG_W-1:0]      cfg_data;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [nav_cs_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [nav_cs_pkg::REQ_W-1:0]      s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [nav_cs_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                              m_axis_tlast;

  int fails;
  int outstanding;
  int n_results;
  int n_notes;
  int n_overflows;

  int          cycles = 0;
  int          sent;
  int          stall_left;
  logic        quiet;
  logic        long_nav;
  logic [47:0] own_now;

  nav_carrier_sense_core #(.PENDING_DEPTH(DEPTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  nav_cs_checker #(.PENDING_DEPTH(DEPTH)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_axis_tvalid),
    .s_tready    (s_axis_tready),
    .s_tdata     (s_axis_tdata),
    .s_tuser     (s_axis_tuser),
    .m_tvalid    (m_axis_tvalid),
    .m_tready    (m_axis_tready),
    .m_tdata     (m_axis_tdata),
    .m_tlast     (m_axis_tlast),
    .fails       (fails),
    .outstanding (outstanding),
    .n_results   (n_results),
    .n_notes     (n_notes),
    .n_overflows (n_overflows)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 12);
    else return $urandom_range(30, 80);
  endfunction

  // result side back-pressure
  initial begin
    m_axis_tready = 1'b0;
    stall_left    = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) stall_left = gap_len();
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  function automatic logic [nav_cs_pkg::IN_DATA_W-1:0] pack_event(
      logic [1:0] rxs, logic [2:0] part, logic [1:0] txs, logic fcs,
      logic [47:0] addr, logic [14:0] dur);
    return {1'b0, dur, addr, fcs, txs, part, rxs};
  endfunction

  function automatic logic [nav_cs_pkg::IN_DATA_W-1:0] noise();
    logic [nav_cs_pkg::IN_DATA_W-1:0] v;
    v[31:0]  = $urandom;
    v[63:32] = $urandom;
    v[71:64] = 8'($urandom);
    v[71]    = 1'b0;
    return v;
  endfunction

  function automatic logic [14:0] pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    else if (r < 75) return 15'($urandom_range(1, 12));
    else if (r < 92) return 15'($urandom_range(13, 40));
    else if (!long_nav) return 15'($urandom_range(41, 80));
    else if (r < 97) return 15'($urandom_range(0, 32767));
    else return 15'h7fff;
  endfunction

  function automatic logic [47:0] pick_address();
    int          r;
    logic [47:0] a;
    r = $urandom_range(0, 99);
    a = 48'({$urandom, $urandom});
    if (r < 40) return own_now;
    else if (r < 55) return own_now ^ (48'd1 << $urandom_range(0, 47));
    else if (r < 60) return '1;
    else if (r < 65) return '0;
    else return a;
  endfunction

  // one transfer on the event stream, with an optional gap before it
  task automatic post(input logic [nav_cs_pkg::REQ_W-1:0] req,
                      input logic [nav_cs_pkg::IN_DATA_W-1:0] d);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 35) gap = gap_len();
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tuser  = req;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [nav_cs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nav_cs_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic random_event(output bit counted);
    logic [nav_cs_pkg::IN_DATA_W-1:0] d;
    logic [nav_cs_pkg::REQ_W-1:0]     req;
    int                               pick;
    int                               r;
    d    = noise();
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 9);
    if (pick < 34) begin
      req = nav_cs_pkg::REQ_TICK;
    end else if (pick < 50) begin
      req = nav_cs_pkg::REQ_RX_STATE;
      d[1:0] = (r < 5) ? nav_cs_pkg::RX_IDLE : 2'($urandom_range(0, 3));
    end else if (pick < 58) begin
      req = nav_cs_pkg::REQ_RX_PART;
      d[4:2] = (r < 3) ? nav_cs_pkg::PART_WHOLE :
               (r < 6) ? nav_cs_pkg::PART_DATA : 3'($urandom_range(0, 7));
    end else if (pick < 68) begin
      req = nav_cs_pkg::REQ_TX_STATE;
      d[6:5] = (r < 5) ? nav_cs_pkg::TX_UNDEFINED : 2'($urandom_range(0, 3));
    end else if (pick < 87) begin
      req = nav_cs_pkg::REQ_FRAME_RX;
      d[7]     = (r != 0);
      d[55:8]  = pick_address();
      d[70:56] = pick_duration();
    end else if (pick < 97) begin
      req = nav_cs_pkg::REQ_FRAME_TX;
      d[70:56] = pick_duration();
    end else begin
      req = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    end
    post(req, d);
    counted = (req < REQ_SPARE_LO);
  endtask

  initial begin
    int          ph;
    int          done;
    int          i;
    bit          counted;
    logic [15:0] delay_now;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = nav_cs_pkg::REQ_TICK;
    quiet         = 1'b0;
    long_nav      = 1'b0;
    own_now       = '0;
    sent          = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset state, delay zero, own address zero
    post(nav_cs_pkg::REQ_TICK, '0);
    post(nav_cs_pkg::REQ_RX_STATE, pack_event(nav_cs_pkg::RX_IDLE, '0, '0, 1'b0, '0, '0));
    post(nav_cs_pkg::REQ_RX_PART, pack_event('0, nav_cs_pkg::PART_WHOLE, '0, 1'b0, '0, '0));
    post(nav_cs_pkg::REQ_RX_STATE,
         pack_event(nav_cs_pkg::RX_RECEIVING, '0, '0, 1'b0, '0, '0));
    post(nav_cs_pkg::REQ_RX_PART, pack_event('0, nav_cs_pkg::PART_DATA, '0, 1'b0, '0, '0));
    post(nav_cs_pkg::REQ_FRAME_RX, pack_event('0, '0, '0, 1'b0, '1, 15'h7fff));
    post(nav_cs_pkg::REQ_FRAME_RX, pack_event('0, '0, '0, 1'b1, '0, 15'd9));
    post(nav_cs_pkg::REQ_FRAME_RX, pack_event('0, '0, '0, 1'b1, '1, 15'd2));
    post(nav_cs_pkg::REQ_FRAME_TX, pack_event('0, '0, '0, 1'b0, '0, 15'd1));
    post(nav_cs_pkg::REQ_FRAME_TX, pack_event('0, '0, '0, 1'b0, '0, 15'd0));
    post(nav_cs_pkg::REQ_FRAME_TX, pack_event('0, '0, '0, 1'b0, '0, 15'd3));
    post(nav_cs_pkg::REQ_RX_STATE, pack_event(nav_cs_pkg::RX_IDLE, '0, '0, 1'b0, '0, '0));
    post(REQ_SPARE_HI, {1'b0, {(nav_cs_pkg::IN_DATA_W-1){1'b1}}});
    repeat (3) post(nav_cs_pkg::REQ_TICK, {1'b0, {(nav_cs_pkg::IN_DATA_W-1){1'b1}}});

    // fill the pending queue past its depth, then drain a full tick's worth
    wait_idle();
    own_now = '1;
    write_reg(nav_cs_pkg::CFG_OWN_ADDRESS, own_now);
    write_reg(nav_cs_pkg::CFG_NOTIFY_DELAY, 48'd1);
    for (i = 0; i <= DEPTH; i++)
      post(nav_cs_pkg::REQ_RX_STATE,
           pack_event((i % 2 == 0) ? RX_BUSY : nav_cs_pkg::RX_IDLE, '0, TX_SENDING,
                      1'b0, '0, '0));
    post(nav_cs_pkg::REQ_TICK, '0);
    post(nav_cs_pkg::REQ_TICK, '0);

    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin own_now = 48'({$urandom, $urandom}); delay_now = '0; end
        1: begin own_now = '1; delay_now = 16'd1; end
        2: begin own_now = 48'({$urandom, $urandom}); delay_now = 16'($urandom_range(2, 9)); end
        3: begin own_now = '0; delay_now = '0; end
        default: begin
          own_now   = 48'({$urandom, $urandom});
          delay_now = 16'hffff;
          long_nav  = 1'b1;
        end
      endcase
      write_reg(nav_cs_pkg::CFG_OWN_ADDRESS, own_now);
      write_reg(nav_cs_pkg::CFG_NOTIFY_DELAY, {32'd0, delay_now});
      done = 0;
      while (done < RANDOM_ITEMS / PHASES) begin
        if (done % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
        random_event(counted);
        if (counted) done++;
      end
    end

    quiet = 1'b0;
    wait_idle();
    $display("covered %0d events over %0d register settings, notify delay 0 to 65535 ticks",
             sent, PHASES + 2);
    $display("checked %0d results: %0d notifications, %0d queue overflows",
             n_results, n_notes, n_overflows);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
